FILE: sv/smau_pkg.sv
// Shared types, constants and helper functions for the square matrix arithmetic unit.
// No dependencies; every other file in this folder depends on this package.
package smau_pkg;

    // Matrix dimension and derived widths.
    localparam int DIM    = 4;
    localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ELEM_N = DIM * DIM;
    localparam int ADDR_W = (ELEM_N > 1) ? $clog2(ELEM_N) : 1;

    // Field widths of the item payloads.
    localparam int VAL_W  = 16;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 2;

    // Accumulator holds a sum of DIM full-precision Q16.16 products.
    localparam int ACC_W  = 2 * VAL_W + IDX_W + 1;
    localparam int FRAC_W = 8;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 3'd0,
        CMD_LOAD_B = 3'd1,
        CMD_SCALE  = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_MULT   = 3'd4,
        CMD_TRACE  = 3'd5,
        CMD_READ_A = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MAC_MUL,
        MAC_ADD,
        MAC_PASS
    } mac_op_t;

    typedef struct packed {
        logic    issue;
        logic    clear;
        mac_op_t op;
    } mac_ctrl_t;

    typedef struct packed {
        logic                     a_we;
        logic                     b_we;
        logic [ADDR_W-1:0]        addr;
        logic signed [VAL_W-1:0]  data;
    } wr_req_t;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * DIM + int'(c));
    endfunction

    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
        logic signed [VAL_W-1:0] res;
        if (x > SAT_MAX)
            res = VAL_W'(SAT_MAX);
        else if (x < SAT_MIN)
            res = VAL_W'(SAT_MIN);
        else
            res = x[VAL_W-1:0];
        return res;
    endfunction

endpackage

FILE: sv/smau_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on smau_pkg for the payload widths.
interface smau_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [smau_pkg::CMD_W-1:0]            command;
    logic [smau_pkg::POS_W-1:0]            row_index;
    logic [smau_pkg::POS_W-1:0]            col_index;
    logic signed [smau_pkg::VAL_W-1:0]     operand;

    modport source (output valid, command, row_index, col_index, operand, input ready);
    modport sink   (input valid, command, row_index, col_index, operand, output ready);
endinterface

interface smau_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smau_pkg::VAL_W-1:0]     out_value;
    logic [smau_pkg::POS_W-1:0]            out_row;
    logic [smau_pkg::POS_W-1:0]            out_col;
    logic                                  last_item;

    modport source (output valid, out_value, out_row, out_col, last_item, input ready);
    modport sink   (input valid, out_value, out_row, out_col, last_item, output ready);
endinterface

FILE: sv/smau_store.sv
// Register storage for matrices A and B, cleared at reset, one write port
// and one combinational read port per matrix. Depends on smau_pkg.
module smau_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  smau_pkg::wr_req_t                 wr,
    input  logic [smau_pkg::ADDR_W-1:0]       a_raddr,
    input  logic [smau_pkg::ADDR_W-1:0]       b_raddr,
    output logic signed [smau_pkg::VAL_W-1:0] a_rdata,
    output logic signed [smau_pkg::VAL_W-1:0] b_rdata
);
    import smau_pkg::*;

    logic signed [VAL_W-1:0] a_mem_reg [ELEM_N];
    logic signed [VAL_W-1:0] b_mem_reg [ELEM_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < ELEM_N; n++)
            begin
                a_mem_reg[n] <= '0;
                b_mem_reg[n] <= '0;
            end
        end
        else
        begin
            if (wr.a_we)
                a_mem_reg[wr.addr] <= wr.data;
            if (wr.b_we)
                b_mem_reg[wr.addr] <= wr.data;
        end
    end

    assign a_rdata = a_mem_reg[a_raddr];
    assign b_rdata = b_mem_reg[b_raddr];

endmodule

FILE: sv/smau_mac.sv
// Shared two-stage arithmetic unit: a registered multiply, add or pass term,
// then an accumulator with optional floor shift by 8 and saturation. Depends on smau_pkg.
module smau_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  smau_pkg::mac_ctrl_t               ctrl,
    input  logic signed [smau_pkg::VAL_W-1:0] opa,
    input  logic signed [smau_pkg::VAL_W-1:0] opb,
    input  logic                              shift8,
    output logic signed [smau_pkg::VAL_W-1:0] result
);
    import smau_pkg::*;

    logic signed [2*VAL_W-1:0] prod;
    logic signed [VAL_W:0]     sum;
    logic signed [ACC_W-1:0]   term_next;
    logic signed [ACC_W-1:0]   term_reg;
    logic                      term_valid_reg;
    logic                      clear_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_reg;

    assign prod = opa * opb;
    assign sum  = (VAL_W+1)'(opa) + (VAL_W+1)'(opb);

    always_comb
    begin
        case (ctrl.op)
            MAC_MUL:  term_next = ACC_W'(prod);
            MAC_ADD:  term_next = ACC_W'(sum);
            MAC_PASS: term_next = ACC_W'(opa);
            default:  term_next = ACC_W'(opa);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_valid_reg <= 1'b0;
            clear_reg      <= 1'b0;
        end
        else
        begin
            term_valid_reg <= ctrl.issue;
            clear_reg      <= ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        if (term_valid_reg)
            acc_reg <= acc_next;
    end

    assign acc_next = clear_reg ? term_reg : acc_reg + term_reg;

    // The arithmetic shift rounds toward minus infinity, as the Q8.8 format needs.
    assign result = sat16(shift8 ? (acc_reg >>> FRAC_W) : acc_reg);

endmodule

FILE: sv/square_matrix_arith_unit.sv
// Loads write the store directly; read, trace and multiply results wait on the result
// channel, which can stall them.
// Throughput: one command at a time; the single shared multiply-accumulate unit runs
// one term a cycle; each result element then waits in the drain state for it to empty.
// Reset (rst_n, asynchronous, active low) clears both matrices to zero and the sequencer
// to idle; no clearing pass is needed.
module square_matrix_arith_unit (
    input  logic         clk,
    input  logic         rst_n,
    smau_cmd_if.sink     cmd_ch,
    smau_res_if.source   res_ch
);
    import smau_pkg::*;

    state_t                  state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic signed [VAL_W-1:0] operand_reg, operand_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic [POS_W-1:0]        out_row_reg, out_row_next;
    logic [POS_W-1:0]        out_col_reg, out_col_next;
    logic                    out_last_reg, out_last_next;

    logic                    accept;
    logic                    in_inside;
    logic [ADDR_W-1:0]       in_addr;
    logic                    single_term;
    logic                    k_last;
    logic                    elem_last;
    logic [ADDR_W-1:0]       a_raddr, b_raddr;
    logic signed [VAL_W-1:0] a_rdata, b_rdata;
    logic signed [VAL_W-1:0] opb;
    logic signed [VAL_W-1:0] mac_result;
    logic                    shift8;
    mac_ctrl_t               mac_ctrl;
    wr_req_t                 wr;

    assign accept    = cmd_ch.valid && cmd_ch.ready;
    assign in_inside = (int'(cmd_ch.row_index) < DIM) && (int'(cmd_ch.col_index) < DIM);
    assign in_addr   = elem_addr(IDX_W'(cmd_ch.row_index), IDX_W'(cmd_ch.col_index));

    assign single_term = (cmd_reg == CMD_SCALE) || (cmd_reg == CMD_ADD);
    assign k_last      = single_term || (k_reg == IDX_W'(DIM - 1));
    assign elem_last   = (cmd_reg == CMD_TRACE) ||
                         ((i_reg == IDX_W'(DIM - 1)) && (j_reg == IDX_W'(DIM - 1)));
    assign shift8      = (cmd_reg == CMD_MULT) || (cmd_reg == CMD_SCALE);

    smau_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .a_raddr (a_raddr),
        .b_raddr (b_raddr),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata)
    );

    smau_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .opa    (a_rdata),
        .opb    (opb),
        .shift8 (shift8),
        .result (mac_result)
    );

    // Operand addressing and multiply-accumulate control for the term being issued.
    always_comb
    begin
        if (state_reg == ST_IDLE)
            a_raddr = in_addr;
        else
        begin
            case (cmd_reg)
                CMD_MULT:  a_raddr = elem_addr(i_reg, k_reg);
                CMD_TRACE: a_raddr = elem_addr(k_reg, k_reg);
                default:   a_raddr = elem_addr(i_reg, j_reg);
            endcase
        end

        case (cmd_reg)
            CMD_MULT: b_raddr = elem_addr(k_reg, j_reg);
            default:  b_raddr = elem_addr(i_reg, j_reg);
        endcase

        opb = (cmd_reg == CMD_SCALE) ? operand_reg : b_rdata;

        mac_ctrl.issue = (state_reg == ST_ISSUE);
        mac_ctrl.clear = (k_reg == '0);
        case (cmd_reg)
            CMD_MULT:  mac_ctrl.op = MAC_MUL;
            CMD_SCALE: mac_ctrl.op = MAC_MUL;
            CMD_ADD:   mac_ctrl.op = MAC_ADD;
            default:   mac_ctrl.op = MAC_PASS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        operand_reg   <= operand_next;
        out_value_reg <= out_value_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        operand_next   = operand_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_value_next = out_value_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        wr.a_we        = 1'b0;
        wr.b_we        = 1'b0;
        wr.addr        = in_addr;
        wr.data        = cmd_ch.operand;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_ch.command)
                        CMD_LOAD_A:
                            wr.a_we = in_inside;
                        CMD_LOAD_B:
                            wr.b_we = in_inside;
                        CMD_SCALE, CMD_ADD, CMD_MULT, CMD_TRACE:
                        begin
                            cmd_next     = cmd_ch.command;
                            operand_next = cmd_ch.operand;
                            i_next       = '0;
                            j_next       = '0;
                            k_next       = '0;
                            state_next   = ST_ISSUE;
                        end
                        CMD_READ_A:
                        begin
                            out_value_next = in_inside ? a_rdata : '0;
                            out_row_next   = cmd_ch.row_index;
                            out_col_next   = cmd_ch.col_index;
                            out_last_next  = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end

            ST_ISSUE:
            begin
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                    k_next = k_reg + 1'b1;
            end

            ST_DRAIN:
                state_next = ST_FINISH;

            ST_FINISH:
            begin
                if (single_term)
                begin
                    // Scale and add write the element back in place and move on.
                    wr.a_we = 1'b1;
                    wr.addr = elem_addr(i_reg, j_reg);
                    wr.data = mac_result;
                    if (elem_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_reg == IDX_W'(DIM - 1))
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                            j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    out_value_next = mac_result;
                    out_row_next   = (cmd_reg == CMD_TRACE) ? '0 : POS_W'(i_reg);
                    out_col_next   = (cmd_reg == CMD_TRACE) ? '0 : POS_W'(j_reg);
                    out_last_next  = elem_last;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (res_ch.ready)
                begin
                    if (out_last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_reg == IDX_W'(DIM - 1))
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                            j_next = j_reg + 1'b1;
                    end
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    assign cmd_ch.ready     = (state_reg == ST_IDLE);
    assign res_ch.valid     = (state_reg == ST_EMIT);
    assign res_ch.out_value = out_value_reg;
    assign res_ch.out_row   = out_row_reg;
    assign res_ch.out_col   = out_col_reg;
    assign res_ch.last_item = out_last_reg;

    // The final result of a command returns the block to taking items.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.ready && res_ch.last_item |=> cmd_ch.ready)
        else $error("block not ready after the last result item");

    // A read produces exactly one flagged result in the next cycle.
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd_ch.command == CMD_READ_A) |=> res_ch.valid && res_ch.last_item)
        else $error("read command did not present its result item");

    // The accumulator is only used once the pipeline has drained.
    a_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_FINISH))
        else $error("sequencer skipped the finish step after draining");

endmodule

FILE: tb/sv/tb_square_matrix_arith_unit.sv
// Self-checking testbench for square_matrix_arith_unit: a directed table, then random commands.
// Expected results come from a behavioral matrix model kept inside this file.
// Depends on smau_pkg and the channel interfaces in smau_if.sv.
module tb_square_matrix_arith_unit;
    import smau_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam logic signed [VAL_W-1:0] Q_MAX         = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] Q_MIN         = 16'sh8000;
    localparam logic signed [VAL_W-1:0] Q_ZERO        = 16'sh0000;
    localparam logic signed [VAL_W-1:0] Q_ONE_AND_HALF = 16'sh0180;
    localparam logic signed [VAL_W-1:0] NOISE_OPERAND = 16'sh5A5A;

    localparam int PHASE_ITEMS   = 25;
    localparam int SETTLE_CYCLES = 200;
    localparam int TIMEOUT       = 2000000;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] operand;
    } cmd_item_t;

    typedef struct packed {
        cmd_item_t               item;
        logic                    typed;
        logic signed [VAL_W-1:0] typed_value;
    } stim_row_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic                    last;
    } result_t;

    logic clk;
    logic rst_n;

    smau_cmd_if cmd_ch();
    smau_res_if res_ch();

    square_matrix_arith_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch)
    );

    logic signed [VAL_W-1:0] mat_a [ELEM_N];
    logic signed [VAL_W-1:0] mat_b [ELEM_N];
    result_t                 awaited_results [$];
    result_t                 want;
    int                      error_count = 0;
    int                      src_idle_pct;
    int                      snk_idle_pct;

    // Rows with a typed value are checked against that value instead of the model.
    stim_row_t directed_rows [25] = '{
        '{'{CMD_READ_A, 2'd0, 2'd0, Q_ZERO},         1'b1, Q_ZERO},
        '{'{CMD_TRACE,  2'd0, 2'd0, Q_ZERO},         1'b1, Q_ZERO},
        '{'{CMD_MULT,   2'd0, 2'd0, Q_ZERO},         1'b0, Q_ZERO},
        '{'{CMD_LOAD_A, 2'd0, 2'd0, Q_MAX},          1'b0, Q_ZERO},
        '{'{CMD_LOAD_A, 2'd1, 2'd1, Q_MAX},          1'b0, Q_ZERO},
        '{'{CMD_TRACE,  2'd0, 2'd0, Q_ZERO},         1'b1, Q_MAX},
        '{'{CMD_LOAD_A, 2'd2, 2'd2, Q_MIN},          1'b0, Q_ZERO},
        '{'{CMD_LOAD_A, 2'd3, 2'd3, Q_MIN},          1'b0, Q_ZERO},
        '{'{CMD_LOAD_A, 2'd0, 2'd0, Q_MIN},          1'b0, Q_ZERO},
        '{'{CMD_LOAD_A, 2'd1, 2'd1, Q_MIN},          1'b0, Q_ZERO},
        '{'{CMD_TRACE,  2'd0, 2'd0, Q_ZERO},         1'b1, Q_MIN},
        '{'{CMD_LOAD_B, 2'd1, 2'd1, Q_MIN},          1'b0, Q_ZERO},
        '{'{CMD_LOAD_B, 2'd2, 2'd3, Q_MAX},          1'b0, Q_ZERO},
        '{'{CMD_LOAD_A, 2'd2, 2'd3, Q_MAX},          1'b0, Q_ZERO},
        '{'{CMD_LOAD_B, 2'd3, 2'd0, Q_ONE_AND_HALF}, 1'b0, Q_ZERO},
        '{'{CMD_ADD,    2'd0, 2'd0, Q_ZERO},         1'b0, Q_ZERO},
        '{'{CMD_READ_A, 2'd1, 2'd1, Q_ZERO},         1'b1, Q_MIN},
        '{'{CMD_READ_A, 2'd2, 2'd3, Q_ZERO},         1'b1, Q_MAX},
        '{'{CMD_MULT,   2'd0, 2'd0, Q_ZERO},         1'b0, Q_ZERO},
        '{'{CMD_SCALE,  2'd0, 2'd0, Q_MAX},          1'b0, Q_ZERO},
        '{'{CMD_UNUSED, 2'd2, 2'd1, NOISE_OPERAND},  1'b0, Q_ZERO},
        '{'{CMD_READ_A, 2'd3, 2'd0, Q_ZERO},         1'b0, Q_ZERO},
        '{'{CMD_SCALE,  2'd0, 2'd0, Q_MIN},          1'b0, Q_ZERO},
        '{'{CMD_MULT,   2'd0, 2'd0, Q_ZERO},         1'b0, Q_ZERO},
        '{'{CMD_TRACE,  2'd0, 2'd0, Q_ZERO},         1'b0, Q_ZERO}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] clip16(input longint x);
        if (x > 32767)
            return Q_MAX;
        if (x < -32768)
            return Q_MIN;
        return VAL_W'(x);
    endfunction

    // Applies one accepted command to the local matrices and queues the results it causes.
    function automatic void predict_matrix_cmd(input cmd_item_t it);
        longint acc;
        int     idx;
        int     i;
        int     j;
        int     k;
        idx = int'(it.row) * DIM + int'(it.col);
        case (it.cmd)
            CMD_LOAD_A: mat_a[idx] = it.operand;
            CMD_LOAD_B: mat_b[idx] = it.operand;
            CMD_SCALE:
                for (i = 0; i < ELEM_N; i++)
                    mat_a[i] = clip16((longint'(mat_a[i]) * longint'($signed(it.operand)))
                                      >>> FRAC_W);
            CMD_ADD:
                for (i = 0; i < ELEM_N; i++)
                    mat_a[i] = clip16(longint'(mat_a[i]) + longint'(mat_b[i]));
            CMD_MULT:
                for (i = 0; i < DIM; i++)
                    for (j = 0; j < DIM; j++)
                    begin
                        acc = 0;
                        for (k = 0; k < DIM; k++)
                            acc += longint'(mat_a[i * DIM + k]) * longint'(mat_b[k * DIM + j]);
                        awaited_results.push_back('{value: clip16(acc >>> FRAC_W),
                                                    row: POS_W'(i), col: POS_W'(j),
                                                    last: (i == DIM - 1) && (j == DIM - 1)});
                    end
            CMD_TRACE:
            begin
                acc = 0;
                for (i = 0; i < DIM; i++)
                    acc += longint'(mat_a[i * DIM + i]);
                awaited_results.push_back('{value: clip16(acc), row: '0, col: '0, last: 1'b1});
            end
            CMD_READ_A:
                awaited_results.push_back('{value: mat_a[idx], row: it.row, col: it.col,
                                            last: 1'b1});
            default: ;
        endcase
    endfunction

    // Mostly loads with random content, so that the arithmetic commands see varied matrices.
    function automatic cmd_item_t random_item();
        cmd_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            it.cmd = CMD_LOAD_A;
        else if (pick < 55)
            it.cmd = CMD_LOAD_B;
        else if (pick < 67)
            it.cmd = CMD_READ_A;
        else if (pick < 73)
            it.cmd = CMD_TRACE;
        else if (pick < 81)
            it.cmd = CMD_MULT;
        else if (pick < 88)
            it.cmd = CMD_ADD;
        else if (pick < 96)
            it.cmd = CMD_SCALE;
        else
            it.cmd = CMD_UNUSED;
        it.row = POS_W'($urandom_range(0, DIM - 1));
        it.col = POS_W'($urandom_range(0, DIM - 1));
        if ($urandom_range(0, 1) == 1)
            it.operand = VAL_W'($urandom);
        else
            it.operand = VAL_W'(int'($urandom_range(0, 1023)) - 512);
        return it;
    endfunction

    // Called at a clock edge; returns at the edge where the item is accepted, valid still high.
    task automatic send_cmd(input cmd_item_t it);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= it.cmd;
        cmd_ch.row_index <= it.row;
        cmd_ch.col_index <= it.col;
        cmd_ch.operand   <= it.operand;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predict_matrix_cmd(it);
    endtask

    task automatic hold_until_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        res_ch.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result: value %0d row %0d col %0d last %0d",
                         $time, res_ch.out_value, res_ch.out_row, res_ch.out_col,
                         res_ch.last_item);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (res_ch.out_value !== want.value || res_ch.out_row !== want.row ||
                    res_ch.out_col !== want.col || res_ch.last_item !== want.last)
                begin
                    $display("%0t: mismatch: expected value %0d row %0d col %0d last %0d,",
                             $time, want.value, want.row, want.col, want.last,
                             " got value %0d row %0d col %0d last %0d",
                             res_ch.out_value, res_ch.out_row, res_ch.out_col,
                             res_ch.last_item);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        cmd_item_t it;
        int        counted;
        int        phase;
        counted          = 0;
        mat_a            = '{default: '0};
        mat_b            = '{default: '0};
        src_idle_pct     = 9;
        snk_idle_pct     = 80;
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_LOAD_A;
        cmd_ch.row_index = '0;
        cmd_ch.col_index = '0;
        cmd_ch.operand   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            send_cmd(directed_rows[n].item);
            if (directed_rows[n].typed)
                awaited_results[$].value = directed_rows[n].typed_value;
        end

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                hold_until_drained();
                src_idle_pct = 80;
                snk_idle_pct = 9;
            end
            else if (phase == 2)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // Ignored commands do not count toward the item total.
            while (counted < (phase + 1) * PHASE_ITEMS)
            begin
                it = random_item();
                send_cmd(it);
                if (it.cmd != CMD_UNUSED)
                    counted++;
            end
        end

        cmd_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
